### rtl/intc_pkg.sv
// Shared types and codes for the interrupt controller register block.
// Holds the access and result item layouts and the register offset map.
// No dependencies.
`default_nettype none

package intc_pkg;

  localparam int unsigned DataWidth = 32;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [3:0] OFF_IRQ_STATUS  = 4'd0;
  localparam logic [3:0] OFF_FIQ_STATUS  = 4'd1;
  localparam logic [3:0] OFF_RAW_STATUS  = 4'd2;
  localparam logic [3:0] OFF_SELECT      = 4'd3;
  localparam logic [3:0] OFF_ENABLE      = 4'd4;
  localparam logic [3:0] OFF_ENABLE_CLR  = 4'd5;
  localparam logic [3:0] OFF_SOFT        = 4'd6;
  localparam logic [3:0] OFF_SOFT_CLR    = 4'd7;
  localparam logic [3:0] OFF_PROTECT     = 4'd8;
  localparam logic [3:0] OFF_VECTOR      = 4'd12;
  localparam logic [3:0] OFF_DEF_VECTOR  = 4'd13;

  typedef struct packed {
    logic [1:0]           mode;
    logic [3:0]           reg_offset;
    logic [DataWidth-1:0] write_data;
    logic                 privileged;
    logic [DataWidth-1:0] source_lines;
  } access_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 access_blocked;
    logic                 irq_request;
    logic                 fiq_request;
  } result_t;

endpackage

`default_nettype wire

### rtl/intc_core.sv
// Register file and status logic of the interrupt controller.
// Serves one access per advance and computes the request outputs.
// Depends on intc_pkg.
`default_nettype none

module intc_core
  import intc_pkg::*;
#(
  parameter logic [DataWidth-1:0] SrcMask = 32'hFFFF_FFFF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    advance,
  input  access_t      item,
  output result_t      res
);

  logic [DataWidth-1:0] fast_select, fast_select_next;
  logic [DataWidth-1:0] source_enable, source_enable_next;
  logic [DataWidth-1:0] soft_request, soft_request_next;
  logic                 protect_flag, protect_flag_next;
  logic [DataWidth-1:0] default_vector, default_vector_next;

  logic [DataWidth-1:0] lines;
  logic [DataWidth-1:0] raw;
  logic [DataWidth-1:0] raw_next;
  logic [DataWidth-1:0] rdata;
  logic                 is_access;
  logic                 blocked;

  always_comb begin
    lines     = item.source_lines & SrcMask;
    raw       = lines | soft_request;
    is_access = (item.mode == MODE_READ) || (item.mode == MODE_WRITE);
    blocked   = is_access && protect_flag && !item.privileged;

    fast_select_next    = fast_select;
    source_enable_next  = source_enable;
    soft_request_next   = soft_request;
    protect_flag_next   = protect_flag;
    default_vector_next = default_vector;
    rdata               = '0;

    if (!blocked && item.mode == MODE_READ) begin
      unique case (item.reg_offset)
        OFF_IRQ_STATUS: rdata = raw & source_enable & ~fast_select;
        OFF_FIQ_STATUS: rdata = raw & source_enable & fast_select;
        OFF_RAW_STATUS: rdata = raw;
        OFF_SELECT:     rdata = fast_select;
        OFF_ENABLE:     rdata = source_enable;
        OFF_SOFT:       rdata = soft_request;
        OFF_PROTECT:    rdata = {{(DataWidth-1){1'b0}}, protect_flag};
        OFF_VECTOR:     rdata = default_vector;
        OFF_DEF_VECTOR: rdata = default_vector;
        default:        rdata = '0;
      endcase
    end

    if (!blocked && item.mode == MODE_WRITE) begin
      unique case (item.reg_offset)
        OFF_SELECT:     fast_select_next    = item.write_data & SrcMask;
        OFF_ENABLE:     source_enable_next  = item.write_data & SrcMask;
        OFF_ENABLE_CLR: source_enable_next  = source_enable & ~item.write_data;
        OFF_SOFT:       soft_request_next   = item.write_data & SrcMask;
        OFF_SOFT_CLR:   soft_request_next   = soft_request & ~item.write_data;
        OFF_PROTECT:    protect_flag_next   = item.write_data[0];
        OFF_DEF_VECTOR: default_vector_next = item.write_data;
        default:        ;
      endcase
    end

    raw_next           = lines | soft_request_next;
    res.read_data      = rdata;
    res.access_blocked = blocked;
    res.irq_request    = |(raw_next & source_enable_next & ~fast_select_next);
    res.fiq_request    = |(raw_next & source_enable_next & fast_select_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_select    <= '0;
      source_enable  <= '0;
      soft_request   <= '0;
      protect_flag   <= 1'b0;
      default_vector <= '0;
    end else if (advance) begin
      fast_select    <= fast_select_next;
      source_enable  <= source_enable_next;
      soft_request   <= soft_request_next;
      protect_flag   <= protect_flag_next;
      default_vector <= default_vector_next;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(fast_select) && $stable(source_enable) &&
                 $stable(soft_request) && $stable(protect_flag) &&
                 $stable(default_vector))
    else $error("intc_core: state changed without an item");

  a_blocked_no_write: assert property (@(posedge clk) disable iff (rst)
    advance && blocked |=> $stable(fast_select) && $stable(source_enable) &&
                           $stable(soft_request) && $stable(protect_flag))
    else $error("intc_core: refused access changed state");

  a_blocked_zero_read: assert property (@(posedge clk) disable iff (rst)
    blocked |-> (rdata == '0))
    else $error("intc_core: refused access returned data");

  a_unimplemented_zero: assert property (@(posedge clk) disable iff (rst)
    ((fast_select | source_enable | soft_request) & ~SrcMask) == '0)
    else $error("intc_core: unimplemented source bit set");

endmodule

`default_nettype wire

### rtl/interrupt_controller_registers_unit.sv
// An accepted item waits in the access register until the core advances; its
// result is then registered. Throughput: one item per cycle; the access and
// result registers form a two-stage pipeline that stalls only when the result
// side stalls. Reset (rst, synchronous): the valid flags and core status state
// clear to zero, both pipeline stages empty. Depends on intc_pkg and intc_core.
`default_nettype none

module interrupt_controller_registers_unit
  import intc_pkg::*;
#(
  parameter int unsigned NUM_SOURCES = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic access_valid,
  output logic      access_stall,
  input  access_t   access,
  output logic      result_valid,
  input  wire logic result_stall,
  output result_t   result
);

  localparam logic [DataWidth-1:0] SrcMask =
    DataWidth'((64'd1 << NUM_SOURCES) - 64'd1);

  logic    stage_valid;
  access_t stage_item;
  logic    advance;
  result_t core_res;

  assign advance      = stage_valid && (!result_valid || !result_stall);
  assign access_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!access_stall) begin
      stage_valid <= access_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!access_stall && access_valid) begin
      stage_item <= access;
    end
  end

  intc_core #(
    .SrcMask(SrcMask)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .item   (stage_item),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_res;
    end
  end

endmodule

`default_nettype wire
